### sv/ddpi_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the pose integrator.
// No dependencies; every other file imports this package.
package ddpi_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int CNT_W        = $clog2(CORDIC_STEPS);
	localparam int ATAN_IDX_W   = 5;
	localparam int CFG_IDX_W    = 1;

	localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
	localparam logic signed [31:0] QUARTER_TURN    = 32'sd1073741824;
	localparam logic [31:0]        HALF_TURN       = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_METERS_PER_TICK = 1'b0,
		REG_ANGLE_PER_TICK  = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		CMD_TICK     = 1'b0,
		CMD_SET_POSE = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MDIST,
		ST_MDTH,
		ST_FOLD,
		ST_ROT,
		ST_MCOS,
		ST_MSIN,
		ST_ADDY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} cordic_ctrl_t;

	// arctan(2^-i) in binary-angle units (2^31 = pi)
	function automatic logic signed [31:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [31:0] v;
		case (idx)
			5'd0:  v = 32'sd536870912;
			5'd1:  v = 32'sd316933406;
			5'd2:  v = 32'sd167458907;
			5'd3:  v = 32'sd85004756;
			5'd4:  v = 32'sd42667331;
			5'd5:  v = 32'sd21354465;
			5'd6:  v = 32'sd10679838;
			5'd7:  v = 32'sd5340245;
			5'd8:  v = 32'sd2670163;
			5'd9:  v = 32'sd1335087;
			5'd10: v = 32'sd667544;
			5'd11: v = 32'sd333772;
			5'd12: v = 32'sd166886;
			5'd13: v = 32'sd83443;
			5'd14: v = 32'sd41722;
			5'd15: v = 32'sd20861;
			5'd16: v = 32'sd10430;
			5'd17: v = 32'sd5215;
			5'd18: v = 32'sd2608;
			5'd19: v = 32'sd1304;
			5'd20: v = 32'sd652;
			5'd21: v = 32'sd326;
			5'd22: v = 32'sd163;
			5'd23: v = 32'sd81;
			5'd24: v = 32'sd41;
			5'd25: v = 32'sd20;
			5'd26: v = 32'sd10;
			5'd27: v = 32'sd5;
			5'd28: v = 32'sd3;
			5'd29: v = 32'sd1;
			5'd30: v = 32'sd1;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

### sv/differential_drive_pose_integrator.sv
// Dead-reckoning pose integrator. Integrate: distance and heading multiplies, fold, CORDIC loop,
// cos/sin multiplies and y add in turn; the next item waits until the result is loaded, set by
// the CORDIC loop and the single shared 33x32 multiplier. Set pose loads the pose, no result.
// A pending result waits in the output register while the next item is taken.
// arst_n clears pose, heading, configuration registers and handshake state at once; no clearing pass.
module differential_drive_pose_integrator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ddpi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic signed [15:0]           left_ticks,
	input  logic signed [15:0]           right_ticks,
	input  logic [63:0]                  time_us,
	input  logic signed [31:0]           pose_x,
	input  logic signed [31:0]           pose_y,
	input  logic signed [31:0]           pose_heading,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [63:0]                  stamp_us,
	output logic signed [31:0]           out_x,
	output logic signed [31:0]           out_y,
	output logic signed [31:0]           out_heading
);
	import ddpi_pkg::*;

	state_t state_q, state_nxt;

	logic [31:0]        mpt_q, apt_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [31:0]        heading_q, newhead_q;
	logic signed [16:0] sum_q, diff_q;
	logic [63:0]        time_q;
	logic signed [64:0] prod_q;
	logic signed [32:0] dist_q;
	logic               out_valid_q;

	logic               in_xfer, out_free, load_out;
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [64:0] mul_p;
	logic signed [64:0] rnd;
	logic signed [33:0] delta;
	logic signed [31:0] acc_in, acc_out;
	logic signed [34:0] acc_sum;
	logic [31:0]        mid;
	logic signed [31:0] cos_v, sin_v;
	logic               rot_last;
	cordic_ctrl_t       cctrl;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = (state_q == ST_DONE) && out_free;

	ddpi_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (cctrl),
		.angle   (mid),
		.cos_val (cos_v),
		.sin_val (sin_v),
		.last    (rot_last)
	);

	// sequencer
	always_comb begin
		state_nxt  = state_q;
		cctrl.load = 1'b0;
		cctrl.step = 1'b0;
		case (state_q)
			ST_IDLE:  if (in_xfer && (cmd == CMD_TICK)) state_nxt = ST_MDIST;
			ST_MDIST: state_nxt = ST_MDTH;
			ST_MDTH:  state_nxt = ST_FOLD;
			ST_FOLD: begin
				cctrl.load = 1'b1;
				state_nxt  = ST_ROT;
			end
			ST_ROT: begin
				cctrl.step = 1'b1;
				if (rot_last) state_nxt = ST_MCOS;
			end
			ST_MCOS:  state_nxt = ST_MSIN;
			ST_MSIN:  state_nxt = ST_ADDY;
			ST_ADDY:  state_nxt = ST_DONE;
			ST_DONE:  if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_MDIST: begin
				mul_a = {1'b0, mpt_q};
				mul_b = 32'(sum_q);
			end
			ST_MDTH: begin
				mul_a = {1'b0, apt_q};
				mul_b = 32'(diff_q);
			end
			ST_MSIN: begin
				mul_a = dist_q;
				mul_b = sin_v;
			end
			default: begin
				mul_a = dist_q;
				mul_b = cos_v;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// mid-step heading: heading plus half the heading change, floor-halved
	assign mid = heading_q + prod_q[32:1];

	// shared round-and-saturate accumulate, x then y
	assign rnd     = prod_q + 65'sd1073741824;
	assign delta   = rnd[64:31];
	assign acc_in  = (state_q == ST_ADDY) ? pos_y_q : pos_x_q;
	assign acc_sum = 35'(acc_in) + 35'(delta);
	always_comb begin
		if (acc_sum[34:31] == 4'b0000 || acc_sum[34:31] == 4'b1111) begin
			acc_out = acc_sum[31:0];
		end else if (acc_sum[34]) begin
			acc_out = 32'sh8000_0000;
		end else begin
			acc_out = 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpt_q <= '0;
			apt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_METERS_PER_TICK: mpt_q <= cfg_data;
				REG_ANGLE_PER_TICK:  apt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			heading_q <= '0;
		end else if (in_xfer && (cmd == CMD_SET_POSE)) begin
			pos_x_q   <= pose_x;
			pos_y_q   <= pose_y;
			heading_q <= pose_heading;
		end else if (state_q == ST_MSIN) begin
			pos_x_q <= acc_out;
		end else if (state_q == ST_ADDY) begin
			pos_y_q   <= acc_out;
			heading_q <= newhead_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sum_q  <= 17'(left_ticks) + 17'(right_ticks);
			diff_q <= 17'(right_ticks) - 17'(left_ticks);
			time_q <= time_us;
		end
		case (state_q)
			ST_MDIST, ST_MCOS, ST_MSIN: prod_q <= mul_p;
			ST_MDTH: begin
				dist_q <= prod_q[48:16];
				prod_q <= mul_p;
			end
			ST_FOLD: newhead_q <= heading_q + prod_q[31:0];
			default: ;
		endcase
		if (load_out) begin
			stamp_us    <= time_q;
			out_x       <= pos_x_q;
			out_y       <= pos_y_q;
			out_heading <= heading_q;
		end
	end

endmodule

### sv/ddpi_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per step, shared barrel shifts.
// Depends on ddpi_pkg (step count, gain, arctangent table, control struct).
module ddpi_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ddpi_pkg::cordic_ctrl_t ctrl,
	input  logic [31:0]           angle,
	output logic signed [31:0]    cos_val,
	output logic signed [31:0]    sin_val,
	output logic                  last
);
	import ddpi_pkg::*;

	logic signed [31:0] x_q, y_q, z_q;
	logic               flip_q;
	logic [CNT_W-1:0]   cnt_q;

	logic signed [31:0] ang_s, xs, ys, atan_v;
	logic               wide;

	assign ang_s  = $signed(angle);
	assign wide   = (ang_s > QUARTER_TURN) || (ang_s < -QUARTER_TURN);
	assign xs     = x_q >>> cnt_q;
	assign ys     = y_q >>> cnt_q;
	assign atan_v = atan_lut(ATAN_IDX_W'(cnt_q));
	assign last   = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

	// outside +/- a quarter turn: rotate by half a turn, negate the results
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= '0;
		end else if (ctrl.step && !last) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q    <= CORDIC_GAIN_Q30;
			y_q    <= '0;
			z_q    <= wide ? $signed(angle + HALF_TURN) : ang_s;
			flip_q <= wide;
		end else if (ctrl.step) begin
			if (!z_q[31]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end
		end
	end

endmodule

### sv/ddpi_checker.sv
// Port-level checks for the pose integrator, bound to the top level.
// Depends on ddpi_pkg for the command codes.
module ddpi_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         cmd,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [63:0]                  stamp_us,
	input logic signed [31:0]           out_x,
	input logic signed [31:0]           out_y,
	input logic signed [31:0]           out_heading
);
	import ddpi_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stamp_us) && $stable(out_x)
			&& $stable(out_y) && $stable(out_heading))
		else $error("result changed while stalled");

	// an integrate transfer makes the block busy
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_TICK) |=> !in_ready)
		else $error("ready after integrate transfer");

	// set pose leaves the block ready again in the next cycle
	a_set_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_SET_POSE) |=> in_ready)
		else $error("busy after set pose");

	// set pose never produces a result
	a_set_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_SET_POSE) |=> !$rose(out_valid))
		else $error("result after set pose");

endmodule

bind differential_drive_pose_integrator ddpi_checker u_ddpi_checker (.*);

### tb/sv/differential_drive_pose_integrator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for differential_drive_pose_integrator: directed and random tick
// and set-pose traffic under several idling patterns, checked against a pose scoreboard.
// Depends on ddpi_pkg and the block's RTL.
module differential_drive_pose_integrator_tb;
	import ddpi_pkg::*;

	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int SETTLE_CYCLES   = 2 * (CORDIC_STEPS + 8);
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int HOLD_PHASE      = 4;
	localparam int PHASE_COUNT     = 8;
	localparam int PHASE_ITEMS     = 179;
	localparam int MAX_REPORTS     = 10;

	// arctan(2^-i), binary angle with 2^31 = pi
	localparam longint ATAN_BAM [0:31] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	// register settings per phase; phases 3 and 6 draw both at random
	localparam logic [31:0] MPT_SETTINGS [0:PHASE_COUNT-1] = '{
		32'h0, 32'hFFFF_FFFF, 32'd2147483, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'd2147483
	};
	localparam logic [31:0] APT_SETTINGS [0:PHASE_COUNT-1] = '{
		32'h0, 32'hFFFF_FFFF, 32'd683565, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'd683565
	};

	typedef struct {
		logic [63:0]        stamp;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] heading;
	} pose_t;

	class pose_scoreboard;
		logic [31:0]        meters_per_tick;
		logic [31:0]        angle_per_tick;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        heading;
		pose_t              expected_poses[$];
		int                 mismatches;

		function new();
			meters_per_tick = '0;
			angle_per_tick  = '0;
			pos_x           = '0;
			pos_y           = '0;
			heading         = '0;
			mismatches      = 0;
		endfunction

		function void write_reg(input cfg_reg_t idx, input logic [31:0] val);
			case (idx)
				REG_METERS_PER_TICK: meters_per_tick = val;
				REG_ANGLE_PER_TICK:  angle_per_tick  = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_poses.size();
		endfunction

		function logic signed [31:0] clamp32(input longint v);
			if (v > 64'sd2147483647)
				return 32'sh7FFF_FFFF;
			if (v < -64'sd2147483648)
				return 32'sh8000_0000;
			return v[31:0];
		endfunction

		// cos and sin in Q2.30; angles beyond a quarter turn are folded by half a turn
		function void cordic_rotate(input logic [31:0] ang, output longint cos_q30,
				output longint sin_q30);
			longint      z;
			longint      x;
			longint      y;
			longint      nx;
			logic [31:0] folded;
			bit          flip;
			z    = longint'($signed(ang));
			flip = 1'b0;
			if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
				folded = ang + HALF_TURN;
				z      = longint'($signed(folded));
				flip   = 1'b1;
			end
			x = longint'(CORDIC_GAIN_Q30);
			y = 0;
			for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y  = y + (x >>> i);
					z  = z - ATAN_BAM[i];
				end else begin
					nx = x + (y >>> i);
					y  = y - (x >>> i);
					z  = z + ATAN_BAM[i];
				end
				x = nx;
			end
			cos_q30 = flip ? -x : x;
			sin_q30 = flip ? -y : y;
		endfunction

		function void accept_item(input cmd_t op, input logic signed [15:0] l_d,
				input logic signed [15:0] r_d, input logic [63:0] t,
				input logic signed [31:0] px, input logic signed [31:0] py,
				input logic signed [31:0] ph);
			longint      travel;
			longint      dth;
			longint      half;
			longint      cos_q30;
			longint      sin_q30;
			logic [31:0] mid;
			pose_t       p;
			if (op == CMD_SET_POSE) begin
				pos_x   = px;
				pos_y   = py;
				heading = ph;
				return;
			end
			travel = (longint'({32'd0, meters_per_tick}) * (longint'(l_d) + longint'(r_d))) >>> 16;
			dth  = longint'({32'd0, angle_per_tick}) * (longint'(r_d) - longint'(l_d));
			half = dth >>> 1;
			mid  = heading + half[31:0];
			cordic_rotate(mid, cos_q30, sin_q30);
			pos_x   = clamp32(longint'(pos_x) + ((travel * cos_q30 + 64'sd1073741824) >>> 31));
			pos_y   = clamp32(longint'(pos_y) + ((travel * sin_q30 + 64'sd1073741824) >>> 31));
			heading = heading + dth[31:0];
			p.stamp   = t;
			p.x       = pos_x;
			p.y       = pos_y;
			p.heading = heading;
			expected_poses.push_back(p);
		endfunction

		function void check_pose(input logic [63:0] st, input logic signed [31:0] x,
				input logic signed [31:0] y, input logic signed [31:0] h);
			pose_t e;
			if (expected_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected pose: stamp %h x %h y %h heading %h",
						$time, st, x, y, h);
				return;
			end
			e = expected_poses.pop_front();
			if (st !== e.stamp || x !== e.x || y !== e.y || h !== e.heading) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: pose mismatch (exp/act): stamp %h/%h x %h/%h y %h/%h hdg %h/%h",
						$time, e.stamp, st, e.x, x, e.y, y, e.heading, h);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [31:0]            cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic                   cmd;
	logic signed [15:0]     left_ticks;
	logic signed [15:0]     right_ticks;
	logic [63:0]            time_us;
	logic signed [31:0]     pose_x;
	logic signed [31:0]     pose_y;
	logic signed [31:0]     pose_heading;
	logic                   out_valid;
	logic                   out_ready;
	logic [63:0]            stamp_us;
	logic signed [31:0]     out_x;
	logic signed [31:0]     out_y;
	logic signed [31:0]     out_heading;

	pose_scoreboard tracker;
	int             tx_idle_pct;
	int             rx_stall_pct;
	int             phase_num;
	int             items_in_phase;
	int             quiet_cycles = 0;
	bit             held_off;

	differential_drive_pose_integrator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.left_ticks   (left_ticks),
		.right_ticks  (right_ticks),
		.time_us      (time_us),
		.pose_x       (pose_x),
		.pose_y       (pose_y),
		.pose_heading (pose_heading),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.stamp_us     (stamp_us),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_heading  (out_heading)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// scoreboard taps and watchdog; all sampling happens at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				tracker.check_pose(stamp_us, out_x, out_y, out_heading);
			if (cfg_we)
				tracker.write_reg(cfg_reg_t'(cfg_index), cfg_data);
			if (in_valid && in_ready)
				tracker.accept_item(cmd_t'(cmd), left_ticks, right_ticks, time_us,
					pose_x, pose_y, pose_heading);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d poses outstanding", $time,
					tracker.pending());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// result side: random stalls, plus one long hold-off so the block backs up
	initial begin
		out_ready = 1'b0;
		held_off  = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && phase_num == HOLD_PHASE && items_in_phase >= 16) begin
				out_ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				held_off = 1'b1;
			end else begin
				out_ready = ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_item(input cmd_t op, input logic signed [15:0] l_d,
			input logic signed [15:0] r_d, input logic [63:0] t,
			input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [31:0] ph);
		while ($urandom_range(99) < tx_idle_pct)
			@(negedge clk) in_valid = 1'b0;
		@(negedge clk);
		in_valid     = 1'b1;
		cmd          = op;
		left_ticks   = l_d;
		right_ticks  = r_d;
		time_us      = t;
		pose_x       = px;
		pose_y       = py;
		pose_heading = ph;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// pose fields are don't-care on a tick, deltas and stamp on a set pose
	task automatic send_tick(input logic signed [15:0] l_d, input logic signed [15:0] r_d);
		send_item(CMD_TICK, l_d, r_d, {$urandom, $urandom}, $urandom, $urandom, $urandom);
	endtask

	task automatic send_pose(input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [31:0] ph);
		send_item(CMD_SET_POSE, 16'($urandom), 16'($urandom), {$urandom, $urandom},
			px, py, ph);
	endtask

	function automatic logic signed [15:0] rand_delta();
		case ($urandom_range(9))
			0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			1, 2, 3: return 16'($urandom);
			default: return 16'(int'($urandom_range(600)) - 300);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_position();
		if ($urandom_range(1))
			return 32'($urandom);
		return 32'(int'($urandom_range(33554432)) - 16777216);
	endfunction

	task automatic send_random_item();
		if ($urandom_range(99) < 15)
			send_pose(rand_position(), rand_position(), 32'($urandom));
		else
			send_tick(rand_delta(), rand_delta());
	endtask

	// wait out every pose, then give a trailing set pose time to land
	task automatic drain_block();
		@(negedge clk) in_valid = 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 76; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 76; end
			default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
		endcase
	endtask

	initial begin
		tracker        = new();
		phase_num      = -1;
		items_in_phase = 0;
		tx_idle_pct    = 0;
		rx_stall_pct   = 0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_METERS_PER_TICK;
		cfg_data       = '0;
		in_valid       = 1'b0;
		cmd            = CMD_TICK;
		left_ticks     = '0;
		right_ticks    = '0;
		time_us        = '0;
		pose_x         = '0;
		pose_y         = '0;
		pose_heading   = '0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: 1/256 m per tick, 2^20 binary-angle units per differential tick
		write_reg(REG_METERS_PER_TICK, 32'h0100_0000);
		write_reg(REG_ANGLE_PER_TICK, 32'h0010_0000);
		send_item(CMD_TICK, 16'sd0, 16'sd0, 64'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, '1);
		send_item(CMD_TICK, 16'sh7FFF, 16'sh7FFF, '1, '0, '0, '0);
		send_tick(16'sh8000, 16'sh8000);
		send_tick(16'sh8000, 16'sh7FFF);
		send_tick(16'sh7FFF, 16'sh8000);
		send_tick(16'sd1, -16'sd1);
		send_tick(-16'sd1, 16'sd1);
		// drive into the positive x rail, then the negative y rail
		send_pose(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
		send_tick(16'sh7FFF, 16'sh7FFF);
		send_pose(32'sh0000_0000, 32'sh8000_0000, 32'shC000_0000);
		send_tick(16'sh7FFF, 16'sh7FFF);
		// quarter-turn boundaries of the CORDIC fold
		send_pose(32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh4000_0000);
		send_tick(16'sh7FFF, 16'sh7FFF);
		send_pose(32'sh0000_0000, 32'sh0000_0000, 32'sh4000_0001);
		send_tick(16'sd200, 16'sd200);
		send_pose(32'sh8000_0000, 32'sh0000_0000, 32'sh8000_0000);
		send_tick(16'sh7FFF, 16'sh7FFF);
		send_pose(32'sh0000_0000, 32'sh0000_0000, 32'shBFFF_FFFF);
		send_tick(16'sd200, 16'sd200);
		// heading wraps through +/-pi during the step
		send_pose(32'sh0001_0000, 32'sh0001_0000, 32'sh7FFF_FFF0);
		send_tick(-16'sd100, 16'sd100);
		drain_block();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			set_idling(p % 4);
			write_reg(REG_METERS_PER_TICK, (p == 3 || p == 6) ? $urandom : MPT_SETTINGS[p]);
			write_reg(REG_ANGLE_PER_TICK, (p == 3 || p == 6) ? $urandom : APT_SETTINGS[p]);
			items_in_phase = 0;
			phase_num      = p;
			repeat (PHASE_ITEMS) begin
				send_random_item();
				items_in_phase++;
			end
			drain_block();
		end

		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
sv/ddpi_pkg.sv
sv/ddpi_cordic.sv
sv/differential_drive_pose_integrator.sv
sv/ddpi_checker.sv
tb/sv/differential_drive_pose_integrator_tb.sv
